### src/fsmk_pkg.sv
// Shared constants, types and helpers of the flow shop makespan evaluator.
`default_nettype none

package fsmk_pkg;

  // Table geometry; both counts are powers of two
  localparam int MaxJobs     = 16;
  localparam int MaxMachines = 8;
  localparam int JobW        = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int MachW       = (MaxMachines > 1) ? $clog2(MaxMachines) : 1;
  localparam int AddrW       = JobW + MachW;
  localparam int TableDepth  = 2 ** AddrW;

  // Field widths of the channels
  localparam int ActionW = 2;
  localparam int JobIdW  = 4;
  localparam int MachIdW = 3;
  localparam int PtimeW  = 8;
  localparam int TimeW   = 16;
  localparam int SeqW    = 8;
  localparam int CfgW    = 4;

  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SCHED = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [JobW-1:0]   job;
    logic [MachW-1:0]  mach;
    logic [PtimeW-1:0] ptime;
    logic              last;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic running;
  } back_stat_t;

  // Index of the last machine in use; zero acts as one, too many as all
  function automatic logic [MachW-1:0] last_machine(input logic [CfgW-1:0] used);
    logic [5:0] used_w;
    logic [5:0] last_w;
    used_w = 6'(used);
    if (used_w == 6'd0) begin
      last_w = 6'd0;
    end else if (used_w > 6'(MaxMachines)) begin
      last_w = 6'(MaxMachines - 1);
    end else begin
      last_w = used_w - 6'd1;
    end
    return last_w[MachW-1:0];
  endfunction

endpackage

`default_nettype wire

### src/fsmk_intf.sv
// Channel interfaces of the flow shop makespan evaluator.
`default_nettype none

interface fsmk_in_if import fsmk_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [JobIdW-1:0]  job_id;
  logic [MachIdW-1:0] machine_id;
  logic [PtimeW-1:0]  proc_time;
  logic               last_job;

  modport source (output valid, action, job_id, machine_id, proc_time, last_job,
                  input ready);
  modport sink (input valid, action, job_id, machine_id, proc_time, last_job,
                output ready);
endinterface

interface fsmk_out_if import fsmk_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] makespan;
  logic [SeqW-1:0]  sequence_number;
  logic [TimeW-1:0] best_makespan;
  logic [SeqW-1:0]  best_sequence;

  modport source (output valid, makespan, sequence_number, best_makespan, best_sequence,
                  input ready);
  modport sink (input valid, makespan, sequence_number, best_makespan, best_sequence,
                output ready);
endinterface

interface fsmk_cfg_if import fsmk_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### src/fsmk_front.sv
// Front end: accepts input transactions, decodes them and feeds the queue.
`default_nettype none

module fsmk_front import fsmk_pkg::*; (
  fsmk_in_if.sink  in_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output item_t    item_o
);

  logic [8:0] job_wide;
  logic [5:0] mach_wide;
  logic       accept;
  logic       keep;

  // Take a transaction whenever the queue has room
  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && !q_stat_i.full;

  // Wrap job id into the table, widen machine id for the range check
  assign job_wide  = 9'(in_i.job_id);
  assign mach_wide = 6'(in_i.machine_id);

  // Classify; drop unknown actions and loads aimed past the table's last machine
  always_comb begin
    item_o.job   = job_wide[JobW-1:0];
    item_o.mach  = mach_wide[MachW-1:0];
    item_o.ptime = in_i.proc_time;
    item_o.last  = in_i.last_job;
    item_o.op    = OP_SCHED;
    keep         = 1'b0;
    case (action_e'(in_i.action))
      ACT_LOAD: begin
        item_o.op = OP_LOAD;
        keep      = (mach_wide < 6'(MaxMachines));
      end
      ACT_SCHED: begin
        item_o.op = OP_SCHED;
        keep      = 1'b1;
      end
      ACT_CLEAR: begin
        item_o.op = OP_CLEAR;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept && keep;

endmodule

`default_nettype wire

### src/fsmk_queue.sv
// Short queue of decoded transactions between front and back.
`default_nettype none

module fsmk_queue import fsmk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  input  back_stat_t bstat_i,
  output q_stat_t    q_stat_o,
  output item_t      head_o
);

  item_t            slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign q_stat_o.empty = (count_q == '0);
  assign q_stat_o.full  = (count_q == QCntW'(QueueDepth));
  assign head_o         = slot_q[rd_ptr_q];

  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = bstat_i.pop && !q_stat_o.empty;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### src/fsmk_back.sv
// Back end: time table, per-machine completion update and result register.
`default_nettype none

module fsmk_back import fsmk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            head_i,
  input  q_stat_t          q_stat_i,
  input  logic [MachW-1:0] last_m_i,
  fsmk_out_if.source       out_o,
  output back_stat_t       bstat_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [PtimeW-1:0] table_mem [TableDepth];
  logic [PtimeW-1:0] rdata_q;
  logic [AddrW-1:0]  raddr;
  logic              re;
  logic              we;

  logic [TimeW-1:0] fin_q [MaxMachines];
  logic [MachW-1:0] m_q;
  logic [JobW-1:0]  job_q;
  logic             last_q;
  logic [TimeW-1:0] upper_q;
  logic [SeqW-1:0]  seq_q;
  logic [TimeW-1:0] best_q;
  logic [SeqW-1:0]  best_idx_q;

  logic             out_valid_q, out_valid_d;
  logic [TimeW-1:0] out_span_q;
  logic [SeqW-1:0]  out_seq_q;
  logic [TimeW-1:0] out_best_q;
  logic [SeqW-1:0]  out_best_idx_q;

  logic [TimeW-1:0] cur;
  logic [TimeW-1:0] start_t;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] new_t;
  logic             at_last;
  logic             slot_free;
  logic             better;
  logic             do_start;
  logic             do_step;
  logic             do_end;
  logic             do_emit;
  logic             do_clear;

  // Completion of current machine: max of upper and left, plus time, saturated
  assign cur     = fin_q[m_q];
  assign start_t = (upper_q > cur) ? upper_q : cur;
  assign sum     = {1'b0, start_t} + (TimeW + 1)'(rdata_q);
  assign new_t   = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign at_last = (m_q == last_m_i);
  assign better  = (new_t < best_q);

  assign slot_free = !out_valid_q || out_o.ready;

  // Sequence control: one machine per cycle while running, unless a final result waits for its slot
  always_comb begin
    state_d     = state_q;
    bstat_o.pop = 1'b0;
    we          = 1'b0;
    do_clear    = 1'b0;
    do_start    = 1'b0;
    do_step     = 1'b0;
    do_end      = 1'b0;
    do_emit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          bstat_o.pop = 1'b1;
          case (head_i.op)
            OP_LOAD:  we = 1'b1;
            OP_CLEAR: do_clear = 1'b1;
            OP_SCHED: begin
              do_start = 1'b1;
              state_d  = ST_RUN;
            end
            default: bstat_o.pop = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        if (!at_last) begin
          do_step = 1'b1;
        end else if (!last_q) begin
          do_end  = 1'b1;
          state_d = ST_IDLE;
        end else if (slot_free) begin
          do_emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign bstat_o.running = (state_q == ST_RUN);

  // Fetch machine 0 on start, the next machine on each step
  assign re    = do_start || do_step;
  assign raddr = do_start ? {head_i.job, {MachW{1'b0}}} : {job_q, m_q + 1'b1};

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[{head_i.job, head_i.mach}] <= head_i.ptime;
    end
    if (re) begin
      rdata_q <= table_mem[raddr];
    end
  end

  // Hold the job context while running
  always_ff @(posedge clk_i) begin
    if (do_start) begin
      job_q   <= head_i.job;
      last_q  <= head_i.last;
      m_q     <= '0;
      upper_q <= '0;
    end else if (do_step) begin
      m_q     <= m_q + 1'b1;
      upper_q <= new_t;
    end
  end

  // Completion times, sequence counter and best tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= '{default: '0};
      seq_q       <= '0;
      best_q      <= '1;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (do_clear) begin
        seq_q      <= '0;
        best_q     <= '1;
        best_idx_q <= '0;
      end
      if (do_step || do_end) begin
        fin_q[m_q] <= new_t;
      end
      if (do_emit) begin
        fin_q <= '{default: '0};
        seq_q <= seq_q + 1'b1;
        if (better) begin
          best_q     <= new_t;
          best_idx_q <= seq_q;
        end
      end
    end
  end

  // Result register: load on emit, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (do_emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_span_q     <= new_t;
      out_seq_q      <= seq_q;
      out_best_q     <= better ? new_t : best_q;
      out_best_idx_q <= better ? seq_q : best_idx_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.makespan        = out_span_q;
  assign out_o.sequence_number = out_seq_q;
  assign out_o.best_makespan   = out_best_q;
  assign out_o.best_sequence   = out_best_idx_q;

endmodule

`default_nettype wire

### src/flow_shop_makespan.sv
// Top level of the permutation flow shop makespan evaluator.
//
// Channels: in_i carries load, schedule and clear transactions; out_o carries
// one result per sequence (makespan, sequence number, best makespan and its
// sequence number); cfg_i writes machines_used and is always ready.
// Loads fill a 128-entry time table; schedule transactions stream job ids.
// A front end decodes transactions into a two-entry queue; the back end pops
// one entry per cycle when idle; load and clear are done as they are popped.
// A schedule transaction walks the machines in use: the back end steps
// one machine per cycle through the time table's single read port.
// The result of a final job is loaded into an output register at its last
// machine step and stays there until taken; while it waits, the queue and
// front keep accepting transactions. The back end holds only at a final job
// whose result slot is still occupied.
// Reset clears completion times, sequence counter, best index, sets best
// makespan to all ones and machines_used to 8. The time table is not
// cleared; entries read before they are loaded return arbitrary times.
`default_nettype none

module flow_shop_makespan import fsmk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsmk_cfg_if.sink   cfg_i,
  fsmk_in_if.sink    in_i,
  fsmk_out_if.source out_o
);

  logic [CfgW-1:0] machines_used_q;
  logic            push;
  item_t           push_item;
  item_t           head;
  q_stat_t         q_stat;
  back_stat_t      bstat;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      machines_used_q <= CfgReset;
    end else if (cfg_i.valid) begin
      machines_used_q <= cfg_i.data;
    end
  end

  fsmk_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  fsmk_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .bstat_i  (bstat),
    .q_stat_o (q_stat),
    .head_o   (head)
  );

  fsmk_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .last_m_i (last_machine(machines_used_q)),
    .out_o    (out_o),
    .bstat_o  (bstat)
  );

  // The best makespan never exceeds the makespan it is reported with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.best_makespan <= out_o.makespan))
    else $error("best makespan above reported makespan");

  // The back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A new result only follows a running sequence step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(bstat.running))
    else $error("result raised outside a running job");

  // A full queue that is not popped keeps its entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !bstat.pop) |=> !q_stat.empty)
    else $error("full queue lost entries");

endmodule

`default_nettype wire
